// ===== rtl/tialu_pkg.sv =====
// Shared types and constants for the typed integer ALU with power.
package tialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef enum logic [2:0] {
        OP_AND = 3'd0,
        OP_OR  = 3'd1,
        OP_ADD = 3'd2,
        OP_SUB = 3'd3,
        OP_MUL = 3'd4,
        OP_DIV = 3'd5,
        OP_MOD = 3'd6,
        OP_POW = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_NEG_EXP  = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    typedef struct packed {
        t_opcode                 opcode;
        logic [DATA_WIDTH-1:0]   a_value;
        logic                    a_is_signed;
        logic [DATA_WIDTH-1:0]   b_value;
        logic                    b_is_signed;
    } t_in_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]   result_value;
        logic                    result_is_signed;
        t_status                 status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cnt_zero;
    } t_dp_stat;

endpackage

// ===== rtl/tialu_datapath.sv =====
// Datapath: operand registers, restoring divider, square-and-multiply power, result register.
module tialu_datapath (
    input  logic                  i_clk,
    input  tialu_pkg::t_ctrl_cmd  i_cmd,
    input  tialu_pkg::t_in_item   i_in_data,
    output tialu_pkg::t_dp_stat   o_stat,
    output tialu_pkg::t_out_item  o_out_data
);

    localparam int W = tialu_pkg::DATA_WIDTH;
    localparam int C = tialu_pkg::CNT_W;

    tialu_pkg::t_opcode  r_op;
    logic [W-1:0]        r_a;
    logic [W-1:0]        r_b;
    logic                r_as;
    logic                r_bs;
    logic                r_an;
    logic                r_bn;
    logic [W-1:0]        r_quo;
    logic [W-1:0]        r_rem;
    logic [W-1:0]        r_den;
    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_base;
    logic [W-1:0]        r_exp;
    logic [C-1:0]        r_cnt;
    tialu_pkg::t_out_item r_out;

    logic                w_mixed;
    logic                w_an;
    logic                w_bn;
    logic                w_b_zero;
    logic                w_neg_exp;
    logic [C-1:0]        w_cnt_init;
    logic [W:0]          w_shift;
    logic [W:0]          w_diff;
    logic [W-1:0]        w_mul_ab;
    logic [W-1:0]        w_mul_acc;
    logic [W-1:0]        w_mul_base;
    tialu_pkg::t_out_item w_result;

    // operand decode at load
    always_comb begin
        w_mixed   = i_in_data.a_is_signed | i_in_data.b_is_signed;
        w_an      = w_mixed & i_in_data.a_value[W-1];
        w_bn      = w_mixed & i_in_data.b_value[W-1];
        w_b_zero  = (i_in_data.b_value == '0);
        w_neg_exp = i_in_data.b_is_signed & i_in_data.b_value[W-1];
        unique case (i_in_data.opcode) inside
            tialu_pkg::OP_DIV, tialu_pkg::OP_MOD: begin
                w_cnt_init = w_b_zero ? '0 : C'(W);
            end
            tialu_pkg::OP_POW: begin
                w_cnt_init = w_neg_exp ? '0 : C'(W);
            end
            default: begin
                w_cnt_init = '0;
            end
        endcase
    end

    assign w_shift    = {r_rem, r_quo[W-1]};
    assign w_diff     = w_shift - {1'b0, r_den};
    assign w_mul_ab   = r_a * r_b;
    assign w_mul_acc  = r_acc * r_base;
    assign w_mul_base = r_base * r_base;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_data.opcode;
            r_a    <= i_in_data.a_value;
            r_b    <= i_in_data.b_value;
            r_as   <= i_in_data.a_is_signed;
            r_bs   <= i_in_data.b_is_signed;
            r_an   <= w_an;
            r_bn   <= w_bn;
            r_quo  <= w_an ? (W'(0) - i_in_data.a_value) : i_in_data.a_value;
            r_den  <= w_bn ? (W'(0) - i_in_data.b_value) : i_in_data.b_value;
            r_rem  <= '0;
            r_acc  <= W'(1);
            r_base <= i_in_data.a_value;
            r_exp  <= i_in_data.b_value;
            r_cnt  <= w_cnt_init;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - C'(1);
            if (r_op == tialu_pkg::OP_POW) begin
                if (r_exp[0]) begin
                    r_acc <= w_mul_acc;
                end
                r_base <= w_mul_base;
                r_exp  <= {1'b0, r_exp[W-1:1]};
            end else begin
                if (!w_diff[W]) begin
                    r_rem <= w_diff[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.finish) begin
            r_out <= w_result;
        end
    end

    // result select from the finished operation
    always_comb begin
        w_result.result_value     = r_a;
        w_result.result_is_signed = r_as;
        w_result.status           = tialu_pkg::ST_OK;
        case (r_op)
            tialu_pkg::OP_AND: w_result.result_value = r_a & r_b;
            tialu_pkg::OP_OR:  w_result.result_value = r_a | r_b;
            tialu_pkg::OP_ADD: w_result.result_value = r_a + r_b;
            tialu_pkg::OP_SUB: w_result.result_value = r_a - r_b;
            tialu_pkg::OP_MUL: begin
                w_result.result_value     = w_mul_ab;
                w_result.result_is_signed = r_as | r_bs;
            end
            tialu_pkg::OP_DIV: begin
                if (r_b == '0) begin
                    w_result.status = tialu_pkg::ST_DIV_ZERO;
                end else begin
                    w_result.result_is_signed = r_as | r_bs;
                    w_result.result_value     = (r_an != r_bn) ? (W'(0) - r_quo) : r_quo;
                end
            end
            tialu_pkg::OP_MOD: begin
                if (r_b == '0) begin
                    w_result.status = tialu_pkg::ST_DIV_ZERO;
                end else begin
                    w_result.result_is_signed = r_as | r_bs;
                    w_result.result_value     = r_an ? (W'(0) - r_rem) : r_rem;
                end
            end
            default: begin
                if (r_bs && r_b[W-1]) begin
                    w_result.status = tialu_pkg::ST_NEG_EXP;
                end else begin
                    w_result.result_value = r_acc;
                end
            end
        endcase
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_out_data      = r_out;

endmodule

// ===== rtl/tialu_ctrl.sv =====
// Controller: handshake, iteration sequencing and output valid flag.
module tialu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    input  tialu_pkg::t_dp_stat   i_stat,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output tialu_pkg::t_ctrl_cmd  o_cmd
);

    tialu_pkg::t_state r_state;
    tialu_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tialu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tialu_pkg::S_BUSY;
                end
            end
            tialu_pkg::S_BUSY: begin
                if (i_stat.cnt_zero && w_out_free && !i_in_valid) begin
                    n_state = tialu_pkg::S_IDLE;
                end
            end
            default: n_state = tialu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            tialu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            tialu_pkg::S_BUSY: begin
                o_cmd.step   = !i_stat.cnt_zero;
                o_cmd.finish = i_stat.cnt_zero && w_out_free;
                o_in_ready   = i_stat.cnt_zero && w_out_free;
            end
            default: ;
        endcase
        o_cmd.load = o_in_ready && i_in_valid;
    end

    assign n_out_valid = o_cmd.finish || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tialu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken transfer");

    a_step_not_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (!o_cmd.finish && !o_cmd.load))
        else $error("step overlaps finish or load");

    a_load_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == tialu_pkg::S_BUSY))
        else $error("load did not start operation");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

endmodule

// ===== rtl/typed_integer_alu_with_power_top.sv =====
// Top level: typed integer ALU with power, controller plus datapath.
// No iteration for and/or/add/sub/mul or zero-divisor and negative-exponent cases; div, mod and
// power step through DATA_WIDTH bits, div/mod by restoring division, one quotient bit per cycle,
// power by one exponent bit per cycle. Throughput: one item per cycle for single-step ops while
// the output is taken; during an iterating op no new item is taken until it finishes.
// Reset: synchronous active-low i_rst_n returns the controller to idle and clears the output valid.
module typed_integer_alu_with_power_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tialu_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tialu_pkg::t_out_item  o_out_data
);

    tialu_pkg::t_ctrl_cmd w_cmd;
    tialu_pkg::t_dp_stat  w_stat;

    tialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    tialu_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the typed integer ALU with power.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH  = tialu_pkg::DATA_WIDTH;
    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 600000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    tialu_pkg::t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    tialu_pkg::t_out_item o_out_data;

    tialu_pkg::t_out_item pending_results[$];
    int        error_count  = 0;
    int        cycle_count  = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        recv_hold     = 1'b0;

    typed_integer_alu_with_power_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic tialu_pkg::t_out_item compute_alu_result(tialu_pkg::t_in_item item);
        tialu_pkg::t_out_item  res;
        logic [DATA_WIDTH-1:0] a_mag;
        logic [DATA_WIDTH-1:0] b_mag;
        logic [DATA_WIDTH-1:0] quot;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] base;
        logic                  a_neg;
        logic                  b_neg;
        res.result_value     = item.a_value;
        res.result_is_signed = item.a_is_signed;
        res.status           = tialu_pkg::ST_OK;
        a_neg = item.a_value[DATA_WIDTH-1];
        b_neg = item.b_value[DATA_WIDTH-1];
        case (item.opcode) inside
            tialu_pkg::OP_AND: res.result_value = item.a_value & item.b_value;
            tialu_pkg::OP_OR:  res.result_value = item.a_value | item.b_value;
            tialu_pkg::OP_ADD: res.result_value = item.a_value + item.b_value;
            tialu_pkg::OP_SUB: res.result_value = item.a_value - item.b_value;
            tialu_pkg::OP_MUL: begin
                res.result_is_signed = item.a_is_signed | item.b_is_signed;
                res.result_value     = item.a_value * item.b_value;
            end
            tialu_pkg::OP_DIV, tialu_pkg::OP_MOD: begin
                if (item.b_value == '0) begin
                    res.status = tialu_pkg::ST_DIV_ZERO;
                end else begin
                    res.result_is_signed = item.a_is_signed | item.b_is_signed;
                    if (!res.result_is_signed) begin
                        res.result_value = (item.opcode == tialu_pkg::OP_DIV) ?
                            item.a_value / item.b_value : item.a_value % item.b_value;
                    end else begin
                        // magnitudes as unsigned; most negative maps onto itself
                        a_mag = a_neg ? (~item.a_value + 1'b1) : item.a_value;
                        b_mag = b_neg ? (~item.b_value + 1'b1) : item.b_value;
                        quot  = a_mag / b_mag;
                        rem   = a_mag % b_mag;
                        if (item.opcode == tialu_pkg::OP_DIV)
                            res.result_value = (a_neg != b_neg) ? (~quot + 1'b1) : quot;
                        else
                            res.result_value = a_neg ? (~rem + 1'b1) : rem;
                    end
                end
            end
            default: begin
                if (item.b_is_signed && b_neg) begin
                    res.status = tialu_pkg::ST_NEG_EXP;
                end else begin
                    acc  = DATA_WIDTH'(1);
                    base = item.a_value;
                    for (int i = 0; i < DATA_WIDTH; i++) begin
                        if (item.b_value[i])
                            acc = acc * base;
                        base = base * base;
                    end
                    res.result_value = acc;
                end
            end
        endcase
        return res;
    endfunction

    function automatic tialu_pkg::t_in_item make_item(tialu_pkg::t_opcode op,
                                                      logic [DATA_WIDTH-1:0] a, bit a_s,
                                                      logic [DATA_WIDTH-1:0] b, bit b_s);
        tialu_pkg::t_in_item item;
        item.opcode      = op;
        item.a_value     = a;
        item.a_is_signed = a_s;
        item.b_value     = b;
        item.b_is_signed = b_s;
        return item;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = DATA_WIDTH'(1);
            2:       v = '1;
            3:       v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            4:       v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            5, 6:    v = DATA_WIDTH'($urandom_range(0, 40));
            7:       v = DATA_WIDTH'(-$urandom_range(1, 40));
            default: v = DATA_WIDTH'($urandom());
        endcase
        return v;
    endfunction

    function automatic tialu_pkg::t_in_item random_item();
        return make_item(tialu_pkg::t_opcode'(3'($urandom_range(0, 7))), pick_operand(),
                         1'($urandom_range(0, 1)), pick_operand(),
                         1'($urandom_range(0, 1)));
    endfunction

    task automatic send_item(tialu_pkg::t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(compute_alu_result(item));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DATA_WIDTH + 8) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= recv_hold ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        tialu_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer value %h signed %b status %0d",
                         $time, o_out_data.result_value, o_out_data.result_is_signed,
                         o_out_data.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_value !== want.result_value ||
                    o_out_data.result_is_signed !== want.result_is_signed ||
                    o_out_data.status !== want.status) begin
                    $display("%0t: mismatch expected %h/%b/%0d actual %h/%b/%0d", $time,
                             want.result_value, want.result_is_signed, want.status,
                             o_out_data.result_value, o_out_data.result_is_signed,
                             o_out_data.status);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(make_item(tialu_pkg::OP_AND, 32'hFFFF_FFFF, 1'b0, 32'h0F0F_A5A5, 1'b1));
        send_item(make_item(tialu_pkg::OP_OR,  32'h0000_0000, 1'b1, 32'hF0F0_5A5A, 1'b0));
        send_item(make_item(tialu_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0001, 1'b1));
        send_item(make_item(tialu_pkg::OP_ADD, 32'h7FFF_FFFF, 1'b1, 32'h0000_0001, 1'b1));
        send_item(make_item(tialu_pkg::OP_SUB, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0));
        send_item(make_item(tialu_pkg::OP_MUL, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(tialu_pkg::OP_MUL, 32'h0001_0000, 1'b0, 32'hFFFF_FFFD, 1'b1));
        send_item(make_item(tialu_pkg::OP_DIV, 32'hFFFF_FFFF, 1'b0, 32'h0000_0007, 1'b0));
        send_item(make_item(tialu_pkg::OP_DIV, 32'hFFFF_FFF9, 1'b1, 32'h0000_0002, 1'b1));
        send_item(make_item(tialu_pkg::OP_MOD, 32'hFFFF_FFF9, 1'b1, 32'h0000_0002, 1'b0));
        send_item(make_item(tialu_pkg::OP_MOD, 32'h0000_0007, 1'b0, 32'hFFFF_FFFE, 1'b1));
        // zero divisor
        send_item(make_item(tialu_pkg::OP_DIV, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1));
        send_item(make_item(tialu_pkg::OP_MOD, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0));
        // most negative over minus one, and the most negative value as divisor
        send_item(make_item(tialu_pkg::OP_DIV, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(tialu_pkg::OP_MOD, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(tialu_pkg::OP_DIV, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(tialu_pkg::OP_DIV, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1));
        send_item(make_item(tialu_pkg::OP_MOD, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 1'b0));
        // power: zero exponent, negative exponent, large and wrapping cases
        send_item(make_item(tialu_pkg::OP_POW, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0));
        send_item(make_item(tialu_pkg::OP_POW, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(tialu_pkg::OP_POW, 32'h0000_0003, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(tialu_pkg::OP_POW, 32'h0000_0002, 1'b0, 32'h0000_001F, 1'b1));
        send_item(make_item(tialu_pkg::OP_POW, 32'h0000_0002, 1'b1, 32'h0000_0020, 1'b0));
        send_item(make_item(tialu_pkg::OP_POW, 32'hFFFF_FFFD, 1'b1, 32'h0000_0003, 1'b1));
        send_item(make_item(tialu_pkg::OP_POW, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 1'b0));
        wait_for_drain();
    endtask

    task automatic test_random_phase(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_item(random_item());
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (40) send_item(random_item());
        join
        wait_for_drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(630, 9, 68);
        test_random_phase(630, 68, 9);
        test_random_phase(630, 0, 0);
        test_backpressure();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
